### hw/rtl/gpj_pkg.sv
// Shared constants, types and codes for the game port joystick to pad block.
`default_nettype none

package gpj_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CENTER_BITS = 16;
    localparam int MAPS_BITS = 24;
    localparam int CFG_DATA_BITS = 24;
    localparam int CFG_INDEX_BITS = 8;
    localparam int PAD_WORD_BITS = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        KIND_TRIGGER = 2'd0,
        KIND_SAMPLE  = 2'd1,
        KIND_POLL    = 2'd2
    } kind_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_BUTTON_MAPS = 8'd0,
        REG_CENTER_X    = 8'd1,
        REG_CENTER_Y    = 8'd2,
        REG_PAD_SLOT    = 8'd3
    } cfg_index_t;

    typedef struct packed {
        logic [3:0]            pressed;
        logic                  toggle;
        logic [COUNT_BITS-1:0] latched_x;
        logic [COUNT_BITS-1:0] latched_y;
    } pad_src_t;

endpackage

`default_nettype wire

### hw/rtl/gpj_pad_build.sv
// Combinational builder of the pad byte from buttons, masks and axis counts.
`default_nettype none

module gpj_pad_build (
    input  var gpj_pkg::pad_src_t                      src,
    input  var logic [gpj_pkg::MAPS_BITS-1:0]          button_maps,
    input  var logic [gpj_pkg::CENTER_BITS-1:0]        center_x,
    input  var logic [gpj_pkg::CENTER_BITS-1:0]        center_y,
    output logic [7:0]                                 pad
);
    import gpj_pkg::*;

    localparam int CMP_W = ((COUNT_BITS > CENTER_BITS) ? COUNT_BITS : CENTER_BITS) + 3;

    logic [5:0]       hit;
    logic [CMP_W-1:0] x4;
    logic [CMP_W-1:0] y4;
    logic [CMP_W-1:0] cx1;
    logic [CMP_W-1:0] cy1;
    logic [CMP_W-1:0] cx7;
    logic [CMP_W-1:0] cy7;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            hit[i] = |(src.pressed & button_maps[4*i +: 4]);
        end
    end

    assign x4  = CMP_W'(src.latched_x) << 2;
    assign y4  = CMP_W'(src.latched_y) << 2;
    assign cx1 = CMP_W'(center_x);
    assign cy1 = CMP_W'(center_y);
    assign cx7 = (cx1 << 3) - cx1;
    assign cy7 = (cy1 << 3) - cy1;

    always_comb
    begin
        pad[0] = hit[0] | (src.toggle & hit[4]);
        pad[1] = hit[1] | (src.toggle & hit[5]);
        pad[2] = hit[2];
        pad[3] = hit[3];
        pad[4] = (y4 <= cy1);
        pad[5] = !(y4 <= cy1) && (y4 >= cy7);
        pad[6] = (x4 <= cx1);
        pad[7] = !(x4 <= cx1) && (x4 >= cx7);
    end

endmodule

`default_nettype wire

### hw/rtl/game_port_joystick_to_pad.sv
// Top level of the game port joystick to gamepad word reader.
//
// Channel  Direction  Handshake             Word
// input    in         in_valid / in_ready   kind, port_bits
// output   out        out_valid / out_ready pad_word
// config   in         cfg_we (no wait)      cfg_index, cfg_data
//
// Each accepted word updates the state at its edge; a poll word's result is
// registered at that same edge, in the output register or, behind a waiting
// word, in the skid register. This two-entry output stage lets the block keep
// taking words while one result waits; in_ready drops only when both entries
// are full. Reset clears all state and configuration registers but not the two pad word registers.
`default_nettype none

module game_port_joystick_to_pad (
    input  var logic                                   clk,
    input  var logic                                   rst_n,
    input  var logic                                   in_valid,
    output logic                                       in_ready,
    input  var logic [1:0]                             kind,
    input  var logic [7:0]                             port_bits,
    output logic                                       out_valid,
    input  var logic                                   out_ready,
    output logic [gpj_pkg::PAD_WORD_BITS-1:0]          pad_word,
    input  var logic                                   cfg_we,
    input  var logic [gpj_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  var logic [gpj_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
    import gpj_pkg::*;

    logic [MAPS_BITS-1:0]     maps_reg;
    logic [CENTER_BITS-1:0]   center_x_reg;
    logic [CENTER_BITS-1:0]   center_y_reg;
    logic [1:0]               slot_reg;

    logic [COUNT_BITS-1:0]    count_x_reg, count_x_next;
    logic [COUNT_BITS-1:0]    count_y_reg, count_y_next;
    logic [COUNT_BITS-1:0]    latched_x_reg, latched_x_next;
    logic [COUNT_BITS-1:0]    latched_y_reg, latched_y_next;
    logic [3:0]               pressed_reg, pressed_next;
    logic                     measuring_reg, measuring_next;
    logic                     toggle_reg, toggle_next;

    logic                     out_valid_reg, out_valid_next;
    logic [PAD_WORD_BITS-1:0] out_word_reg, out_word_next;
    logic                     skid_valid_reg, skid_valid_next;
    logic [PAD_WORD_BITS-1:0] skid_word_reg, skid_word_next;

    logic                     accept;
    logic                     push;
    logic                     pop;
    pad_src_t                 src;
    logic [7:0]               pad;
    logic [PAD_WORD_BITS-1:0] result;

    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign push      = accept && (kind == KIND_POLL);
    assign pop       = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign pad_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maps_reg     <= '0;
            center_x_reg <= '0;
            center_y_reg <= '0;
            slot_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BUTTON_MAPS: maps_reg     <= cfg_data[MAPS_BITS-1:0];
                REG_CENTER_X:    center_x_reg <= cfg_data[CENTER_BITS-1:0];
                REG_CENTER_Y:    center_y_reg <= cfg_data[CENTER_BITS-1:0];
                REG_PAD_SLOT:    slot_reg     <= cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    // The poll sees the flipped toggle together with the current latches.
    assign src.pressed   = pressed_reg;
    assign src.toggle    = !toggle_reg;
    assign src.latched_x = latched_x_reg;
    assign src.latched_y = latched_y_reg;

    gpj_pad_build u_pad_build (
        .src         (src),
        .button_maps (maps_reg),
        .center_x    (center_x_reg),
        .center_y    (center_y_reg),
        .pad         (pad)
    );

    always_comb
    begin
        case (slot_reg)
            2'd0:    result = {24'd0, pad};
            2'd1:    result = {16'd0, pad, 8'd0};
            2'd2:    result = {8'd0, pad, 16'd0};
            default: result = {pad, 24'd0};
        endcase
    end

    always_comb
    begin
        count_x_next   = count_x_reg;
        count_y_next   = count_y_reg;
        latched_x_next = latched_x_reg;
        latched_y_next = latched_y_reg;
        pressed_next   = pressed_reg;
        measuring_next = measuring_reg;
        toggle_next    = toggle_reg;
        if (accept)
        begin
            unique case (kind)
                KIND_TRIGGER:
                begin
                    pressed_next   = ~port_bits[7:4];
                    count_x_next   = '0;
                    count_y_next   = '0;
                    measuring_next = 1'b1;
                end
                KIND_SAMPLE:
                begin
                    if (measuring_reg)
                    begin
                        if (port_bits[1:0] == 2'b00)
                        begin
                            latched_x_next = count_x_reg;
                            latched_y_next = count_y_reg;
                            measuring_next = 1'b0;
                        end
                        else
                        begin
                            if (port_bits[0] && (count_x_reg != COUNT_MAX))
                            begin
                                count_x_next = count_x_reg + 1'b1;
                            end
                            if (port_bits[1] && (count_y_reg != COUNT_MAX))
                            begin
                                count_y_next = count_y_reg + 1'b1;
                            end
                        end
                    end
                end
                KIND_POLL:
                begin
                    toggle_next = !toggle_reg;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = push;
                skid_word_next  = result;
            end
            else
            begin
                out_valid_next = push;
                out_word_next  = result;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_word_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_x_reg    <= '0;
            count_y_reg    <= '0;
            latched_x_reg  <= '0;
            latched_y_reg  <= '0;
            pressed_reg    <= '0;
            measuring_reg  <= 1'b0;
            toggle_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            count_x_reg    <= count_x_next;
            count_y_reg    <= count_y_next;
            latched_x_reg  <= latched_x_next;
            latched_y_reg  <= latched_y_next;
            pressed_reg    <= pressed_next;
            measuring_reg  <= measuring_next;
            toggle_reg     <= toggle_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

endmodule

`default_nettype wire

### bench/pad_word_checker.sv
// Checker that predicts every pad word from the accepted words and compares it with the block.
module pad_word_checker
    import gpj_pkg::*;
(
    input  var logic                       clk,
    input  var logic                       rst_n,
    input  var logic                       in_valid,
    input  var logic                       in_ready,
    input  var logic [1:0]                 kind,
    input  var logic [7:0]                 port_bits,
    input  var logic                       out_valid,
    input  var logic                       out_ready,
    input  var logic [PAD_WORD_BITS-1:0]   pad_word,
    input  var logic                       cfg_we,
    input  var logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  var logic [CFG_DATA_BITS-1:0]   cfg_data,
    output int                             fail_count,
    output int                             pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAD_UP    = 4;
    localparam int PAD_DOWN  = 5;
    localparam int PAD_LEFT  = 6;
    localparam int PAD_RIGHT = 7;

    logic [MAPS_BITS-1:0]     map_reg;
    logic [CENTER_BITS-1:0]   center_x_reg;
    logic [CENTER_BITS-1:0]   center_y_reg;
    logic [1:0]               slot_reg;

    logic [COUNT_BITS-1:0]    run_x;
    logic [COUNT_BITS-1:0]    run_y;
    logic [COUNT_BITS-1:0]    held_x;
    logic [COUNT_BITS-1:0]    held_y;
    logic [3:0]               buttons;
    logic                     timing;
    logic                     turbo;

    logic [PAD_WORD_BITS-1:0] pad_expect_q[$];
    logic [PAD_WORD_BITS-1:0] want;

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function logic [PAD_WORD_BITS-1:0] poll_pad_word();
        logic [7:0]  pad;
        logic [3:0]  mask;
        int unsigned x4;
        int unsigned y4;
        int unsigned cx7;
        int unsigned cy7;
        turbo = ~turbo;
        pad = '0;
        for (int i = 0; i < 6; i++)
        begin
            mask = map_reg[4*i +: 4];
            if ((i < 4 || turbo) && (buttons & mask) != 4'd0)
            begin
                pad[i % 4] = 1'b1;
            end
        end
        x4  = 32'(held_x) * 4;
        y4  = 32'(held_y) * 4;
        cx7 = 32'(center_x_reg) * 7;
        cy7 = 32'(center_y_reg) * 7;
        if (x4 <= 32'(center_x_reg))
        begin
            pad[PAD_LEFT] = 1'b1;
        end
        else if (x4 >= cx7)
        begin
            pad[PAD_RIGHT] = 1'b1;
        end
        if (y4 <= 32'(center_y_reg))
        begin
            pad[PAD_UP] = 1'b1;
        end
        else if (y4 >= cy7)
        begin
            pad[PAD_DOWN] = 1'b1;
        end
        return 32'(pad) << (8 * slot_reg);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg       = '0;
            center_x_reg  = '0;
            center_y_reg  = '0;
            slot_reg      = '0;
            run_x         = '0;
            run_y         = '0;
            held_x        = '0;
            held_y        = '0;
            buttons       = '0;
            timing        = 1'b0;
            turbo         = 1'b0;
            pad_expect_q.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pad_expect_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected pad word, expected none, actual %h",
                             $time, pad_word);
                end
                else
                begin
                    want = pad_expect_q.pop_front();
                    if (pad_word !== want)
                    begin
                        fail_count++;
                        $display("%0t: pad word mismatch, expected %h, actual %h",
                                 $time, want, pad_word);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                case (kind)
                    KIND_TRIGGER:
                    begin
                        buttons = ~port_bits[7:4];
                        run_x   = '0;
                        run_y   = '0;
                        timing  = 1'b1;
                    end
                    KIND_SAMPLE:
                    begin
                        if (timing)
                        begin
                            if (port_bits[1:0] == 2'b00)
                            begin
                                held_x = run_x;
                                held_y = run_y;
                                timing = 1'b0;
                            end
                            else
                            begin
                                if (port_bits[0])
                                begin
                                    run_x = bump(run_x);
                                end
                                if (port_bits[1])
                                begin
                                    run_y = bump(run_y);
                                end
                            end
                        end
                    end
                    KIND_POLL:
                    begin
                        pad_expect_q.push_back(poll_pad_word());
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BUTTON_MAPS: map_reg      = cfg_data[MAPS_BITS-1:0];
                    REG_CENTER_X:    center_x_reg = cfg_data[CENTER_BITS-1:0];
                    REG_CENTER_Y:    center_y_reg = cfg_data[CENTER_BITS-1:0];
                    REG_PAD_SLOT:    slot_reg     = cfg_data[1:0];
                    default:
                    begin
                    end
                endcase
            end
            pending_count = pad_expect_q.size();
        end
    end

endmodule

### bench/tb_top.sv
// Top of the testbench: clock, reset, stimulus, receiver stalls and the final verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gpj_pkg::*;

    localparam logic [1:0]                KIND_UNUSED      = 2'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_UNUSED = 8'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LAST_UNUSED  = 8'hFF;

    localparam int LIMIT_CYCLES           = 500000;
    localparam int DRAIN_CYCLES           = 8;
    localparam int HOLD_OFF_CYCLES        = 300;
    localparam int RANDOM_WORDS_PER_PHASE = 100;
    localparam int PHASES                 = 4;
    localparam int LONG_MEASURE           = 40;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic [1:0]                kind      = '0;
    logic [7:0]                port_bits = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [PAD_WORD_BITS-1:0]  pad_word;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    int fail_count;
    int pending_count;
    int cycle_count;
    int words_sent = 0;
    int center_x_now = 0;
    int center_y_now = 0;
    bit idle_on = 1'b1;
    bit hold_go = 1'b0;

    always #2 clk = ~clk;

    game_port_joystick_to_pad u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .port_bits (port_bits),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pad_word  (pad_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pad_word_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .port_bits     (port_bits),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pad_word      (pad_word),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    task automatic send_word(input logic [1:0] k, input logic [7:0] b);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 13))
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        kind      <= k;
        port_bits <= b;
        words_sent++;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] d);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_centers(input logic [CFG_DATA_BITS-1:0] x,
                               input logic [CFG_DATA_BITS-1:0] y);
        cfg_write(REG_CENTER_X, x);
        cfg_write(REG_CENTER_Y, y);
        center_x_now = int'(x[CENTER_BITS-1:0]);
        center_y_now = int'(y[CENTER_BITS-1:0]);
    endtask

    // One measurement with exact axis counts, closed by a word with both one-shots low.
    task automatic run_measure(input int lx, input int ly, input logic [7:0] trig_bits);
        logic [7:0] b;
        send_word(KIND_TRIGGER, trig_bits);
        for (int k = 0; k < lx || k < ly; k++)
        begin
            b = 8'($urandom) & 8'hFC;
            b[0] = (k < lx);
            b[1] = (k < ly);
            send_word(KIND_SAMPLE, b);
        end
        send_word(KIND_SAMPLE, 8'($urandom) & 8'hFC);
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] pick_center();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
        begin
            return CFG_DATA_BITS'($urandom_range(0, 24));
        end
        else if (r == 7)
        begin
            return '0;
        end
        else if (r == 8)
        begin
            return CFG_DATA_BITS'(16'hFFFF);
        end
        return CFG_DATA_BITS'($urandom);
    endfunction

    // For centers up to 48, counts mostly cluster around the left or up and the right or down thresholds.
    function automatic int pick_len(input int c);
        int r;
        int len;
        r = $urandom_range(0, 9);
        if (c > 48)
        begin
            len = $urandom_range(0, 40);
        end
        else if (r < 4)
        begin
            len = c / 4 - 1 + int'($urandom_range(0, 2));
        end
        else if (r < 8)
        begin
            len = (7 * c + 3) / 4 - 1 + int'($urandom_range(0, 2));
        end
        else
        begin
            len = $urandom_range(0, 50);
        end
        if (len < 0)
        begin
            len = 0;
        end
        return len;
    endfunction

    task automatic random_config();
        cfg_write(REG_BUTTON_MAPS, CFG_DATA_BITS'($urandom));
        set_centers(pick_center(), pick_center());
        cfg_write(REG_PAD_SLOT, CFG_DATA_BITS'($urandom));
    endtask

    task automatic random_words(input int n);
        int stop_at;
        int pick;
        stop_at = words_sent + n;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                run_measure(pick_len(center_x_now), pick_len(center_y_now), 8'($urandom));
                repeat ($urandom_range(1, 3)) send_word(KIND_POLL, 8'($urandom));
            end
            else if (pick == 6)
            begin
                send_word(2'($urandom), 8'($urandom));
            end
            else if (pick == 7)
            begin
                send_word(KIND_TRIGGER, 8'($urandom));
                repeat ($urandom_range(0, 6)) send_word(KIND_SAMPLE, 8'($urandom));
                send_word(KIND_POLL, 8'($urandom));
            end
            else
            begin
                send_word(KIND_POLL, 8'($urandom));
            end
        end
    endtask

    initial
    begin
        int stall_left;
        bit held;
        stall_left = 0;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        send_word(KIND_POLL, 8'hFF);
        send_word(KIND_SAMPLE, 8'h03);
        send_word(KIND_UNUSED, 8'hA5);
        send_word(KIND_POLL, 8'h00);
        settle();

        cfg_write(REG_BUTTON_MAPS, 24'h218421);
        set_centers(24'd40, 24'd8);
        cfg_write(REG_PAD_SLOT, 24'd3);
        cfg_write(REG_FIRST_UNUSED, 24'hFFFFFF);
        cfg_write(REG_LAST_UNUSED, 24'h000000);
        run_measure(10, 14, 8'h00);
        send_word(KIND_POLL, 8'h00);
        send_word(KIND_POLL, 8'h00);
        send_word(KIND_TRIGGER, 8'hF0);
        repeat (5) send_word(KIND_SAMPLE, 8'h01);
        run_measure(11, 2, 8'h5F);
        send_word(KIND_POLL, 8'hFF);
        send_word(KIND_POLL, 8'hFF);
        settle();

        cfg_write(REG_BUTTON_MAPS, 24'hFFFFFF);
        set_centers(24'h00FFFF, 24'd0);
        cfg_write(REG_PAD_SLOT, 24'hFFFFFD);
        idle_on = 1'b0;
        run_measure(LONG_MEASURE, 3, 8'h7F);
        idle_on = 1'b1;
        send_word(KIND_POLL, 8'h7F);
        send_word(KIND_POLL, 8'h7F);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            random_config();
            if (p == 1)
            begin
                hold_go <= 1'b1;
                repeat (12) send_word(KIND_POLL, 8'($urandom));
            end
            if (p == PHASES - 1)
            begin
                idle_on = 1'b0;
            end
            random_words(RANDOM_WORDS_PER_PHASE);
        end
        settle();

        if (fail_count == 0 && pending_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
